### rtl/tmh_pkg.sv
// ============================================================================
// tmh_pkg
// Shared types and constants for the touch map and button hit test block.
// ============================================================================
package tmh_pkg;

   // Default geometry and table depth
   localparam int MAX_BUTTONS   = 16;
   localparam int SCREEN_WIDTH  = 480;
   localparam int SCREEN_HEIGHT = 320;

   // Field widths
   localparam int CAL_W   = 10;               // raw readings and calibration values
   localparam int DIFF_W  = CAL_W + 1;        // signed raw difference
   localparam int SIZE_W  = 13;               // screen size up to 8191
   localparam int PROD_W  = DIFF_W + SIZE_W + 1;
   localparam int MAG_W   = PROD_W;           // magnitude of the scaled difference
   localparam int QUO_W   = 16;               // quotient magnitude bits
   localparam int CMP_W   = CAL_W + QUO_W;    // divisor shifted by a quotient bit
   localparam int COORD_W = 16;
   localparam int HIT_W   = 16;
   localparam int COUNT_W = 5;
   localparam int SLOT_W  = 4;
   localparam int ADDR_W  = 3;

   // Divider pipeline: quotient bits resolved per stage
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = QUO_W / DIV_STEP;
   // difference, product, magnitude, divider stages, saturation
   localparam int PIPE_STAGES = DIV_STAGES + 4;

   // Stream word widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 56;

   // Configuration register indexes
   typedef enum logic [ADDR_W-1:0] {
      REG_ROTATION   = 3'd0,
      REG_CAL_LEFT   = 3'd1,
      REG_CAL_RIGHT  = 3'd2,
      REG_CAL_TOP    = 3'd3,
      REG_CAL_BOTTOM = 3'd4,
      REG_MIN_PRESS  = 3'd5,
      REG_MAX_PRESS  = 3'd6,
      REG_BTN_COUNT  = 3'd7
   } tmh_reg_type;

   // Input kind carried on tuser
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_WRITE  = 1'b1
   } tmh_cmd_type;

   // One button rectangle, left in the lowest bits
   typedef struct packed {
      logic [15:0] height;
      logic [15:0] width;
      logic [15:0] top;
      logic [15:0] left;
   } tmh_rect_type;

   // Sideband that travels with each word through the pipeline
   typedef struct packed {
      tmh_cmd_type          cmd;
      logic [SLOT_W-1:0]    slot;
      tmh_rect_type         rect;
      logic                 touched;
      logic                 cal_error;
   } tmh_side_type;

endpackage

### rtl/touch_map_and_button_hit_test.sv
// ============================================================================
// touch_map_and_button_hit_test
// Maps raw touch samples to screen coordinates and tests them against a
// table of button rectangles; button writes update the table in order.
// ============================================================================
//
//  channel | direction | handshake             | word
//  req     | in        | req_tvalid/req_tready | tdata: raw sample + rectangle, tuser: cmd
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: coordinates + hit mask, tuser: cal_error
//  csr     | in        | csr_we                | csr_addr, csr_wdata
//
//  A word enters every cycle while the output is not stalled; a result leaves
//  through eight pipeline stages (difference, scale, magnitude, four divider
//  stages of four quotient bits, saturation) and then the output register.
//  Button writes update the table as they leave the last stage, so every
//  sample sees exactly the writes that were accepted before it.
//  A stall holds each stage; empty stages still fill behind it.
//  Reset is synchronous; it clears the valid bits and loads the configuration defaults.
//
module touch_map_and_button_hit_test #(
   parameter int MAX_BUTTONS   = tmh_pkg::MAX_BUTTONS,
   parameter int SCREEN_WIDTH  = tmh_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tmh_pkg::SCREEN_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   // raw_x, raw_y, raw_pressure, slot, rect_left, rect_top, rect_width,
   // rect_height, zero fill
   input  logic [tmh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // screen_x, screen_y, touched, hit_mask, zero fill
   output logic [tmh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // cal_error
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [tmh_pkg::ADDR_W-1:0]        csr_addr,
   input  logic [tmh_pkg::CAL_W-1:0]         csr_wdata
);
   import tmh_pkg::*;

   localparam int LAST  = PIPE_STAGES - 1;
   localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

   // Configuration registers
   logic               rotation_ff;
   logic [CAL_W-1:0]   cal_left_ff, cal_right_ff, cal_top_ff, cal_bottom_ff;
   logic [CAL_W-1:0]   min_press_ff, max_press_ff;
   logic [COUNT_W-1:0] btn_count_ff;

   // Pipeline control
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] stage_en;
   tmh_side_type           side_ff [PIPE_STAGES];
   tmh_side_type           side_in;
   logic                   out_en;

   // Button table, undefined until written
   tmh_rect_type button_ff [MAX_BUTTONS];

   // Axis operands
   logic [CAL_W-1:0]   raw_x, raw_y, raw_press;
   logic [CAL_W-1:0]   x_from, x_to, y_from, y_to;
   logic [COORD_W-1:0] screen_x, screen_y;

   // Output register
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] screen_x_ff, screen_y_ff;
   logic               touched_ff, cal_error_ff;
   logic [HIT_W-1:0]   hit_mask_ff, hit_mask_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff   <= 1'b0;
         cal_left_ff   <= 10'd0;
         cal_right_ff  <= 10'd1023;
         cal_top_ff    <= 10'd0;
         cal_bottom_ff <= 10'd1023;
         min_press_ff  <= 10'd10;
         max_press_ff  <= 10'd1000;
         btn_count_ff  <= '0;
      end else if (csr_we) begin
         case (tmh_reg_type'(csr_addr))
            REG_ROTATION:   rotation_ff   <= csr_wdata[0];
            REG_CAL_LEFT:   cal_left_ff   <= csr_wdata;
            REG_CAL_RIGHT:  cal_right_ff  <= csr_wdata;
            REG_CAL_TOP:    cal_top_ff    <= csr_wdata;
            REG_CAL_BOTTOM: cal_bottom_ff <= csr_wdata;
            REG_MIN_PRESS:  min_press_ff  <= csr_wdata;
            REG_MAX_PRESS:  max_press_ff  <= csr_wdata;
            REG_BTN_COUNT:  btn_count_ff  <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Unpack the input word
   assign raw_x     = req_tdata[9:0];
   assign raw_y     = req_tdata[19:10];
   assign raw_press = req_tdata[29:20];

   always_comb begin
      side_in.cmd       = tmh_cmd_type'(req_tuser);
      side_in.slot      = req_tdata[33:30];
      side_in.rect      = req_tdata[97:34];
      side_in.touched   = (raw_press > min_press_ff) && (raw_press < max_press_ff);
      side_in.cal_error = (cal_left_ff == cal_right_ff) || (cal_top_ff == cal_bottom_ff);
   end

   // Pick calibration direction by rotation
   always_comb begin
      if (rotation_ff) begin
         x_from = cal_left_ff;
         x_to   = cal_right_ff;
         y_from = cal_bottom_ff;
         y_to   = cal_top_ff;
      end else begin
         x_from = cal_right_ff;
         x_to   = cal_left_ff;
         y_from = cal_top_ff;
         y_to   = cal_bottom_ff;
      end
   end

   // Stage enables: a stage loads when empty or when the next one moves
   assign out_en = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stage_en[LAST] = !valid_ff[LAST] || out_en;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[0];

   // Advance valid bits and sideband
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         side_ff[0] <= side_in;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
         if (stage_en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Raw y gives screen x, raw x gives screen y
   tmh_axis_map #(
      .SIZE (SCREEN_WIDTH)
   ) u_map_x (
      .clock    (clock),
      .stage_en (stage_en),
      .raw      (raw_y),
      .from     (x_from),
      .to       (x_to),
      .result   (screen_x)
   );

   tmh_axis_map #(
      .SIZE (SCREEN_HEIGHT)
   ) u_map_y (
      .clock    (clock),
      .stage_en (stage_en),
      .raw      (raw_x),
      .from     (y_from),
      .to       (y_to),
      .result   (screen_y)
   );

   // Write a button entry as the write word leaves the last stage
   always_ff @(posedge clock) begin
      if (out_en && valid_ff[LAST] && side_ff[LAST].cmd == CMD_WRITE &&
          COUNT_W'(side_ff[LAST].slot) < COUNT_W'(MAX_BUTTONS)) begin
         button_ff[side_ff[LAST].slot[IDX_W-1:0]] <= side_ff[LAST].rect;
      end
   end

   // Hit test against enabled buttons, 16-bit wrapping bounds
   always_comb begin
      logic [COUNT_W-1:0] count_eff;
      logic [15:0]        xh, yh;
      count_eff = (btn_count_ff > COUNT_W'(MAX_BUTTONS)) ? COUNT_W'(MAX_BUTTONS)
                                                          : btn_count_ff;
      hit_mask_in = '0;
      for (int j = 0; j < MAX_BUTTONS; j++) begin
         xh = button_ff[j].left + button_ff[j].width;
         yh = button_ff[j].top + button_ff[j].height;
         hit_mask_in[j] = side_ff[LAST].touched && (COUNT_W'(j) < count_eff) &&
                          (screen_x > button_ff[j].left) && (screen_x < xh) &&
                          (screen_y > button_ff[j].top) && (screen_y < yh);
      end
   end

   // Output register; zero span clears all fields but the error flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= valid_ff[LAST] && side_ff[LAST].cmd == CMD_SAMPLE;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         cal_error_ff <= side_ff[LAST].cal_error;
         if (side_ff[LAST].cal_error) begin
            screen_x_ff <= '0;
            screen_y_ff <= '0;
            touched_ff  <= 1'b0;
            hit_mask_ff <= '0;
         end else begin
            screen_x_ff <= screen_x;
            screen_y_ff <= screen_y;
            touched_ff  <= side_ff[LAST].touched;
            hit_mask_ff <= hit_mask_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = cal_error_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*COORD_W - 1 - HIT_W){1'b0}},
                        hit_mask_ff, touched_ff, screen_y_ff, screen_x_ff};

endmodule

### rtl/tmh_axis_map.sv
// ============================================================================
// tmh_axis_map
// Pipelined linear map of one raw axis: (raw - from) * SIZE / (to - from),
// truncated toward zero and saturated to 16-bit signed.
// ============================================================================
module tmh_axis_map #(
   parameter int SIZE = tmh_pkg::SCREEN_WIDTH
) (
   input  logic                                clock,
   input  logic [tmh_pkg::PIPE_STAGES-1:0]     stage_en,
   input  logic [tmh_pkg::CAL_W-1:0]           raw,
   input  logic [tmh_pkg::CAL_W-1:0]           from,
   input  logic [tmh_pkg::CAL_W-1:0]           to,
   output logic [tmh_pkg::COORD_W-1:0]         result
);
   import tmh_pkg::*;

   localparam logic signed [SIZE_W:0] SIZE_S = (SIZE_W+1)'(SIZE);
   localparam int SAT_STAGE = DIV_STAGES + 3;

   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [DIFF_W-1:0] span_ff, span_in;
   logic signed [DIFF_W-1:0] span1_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Index 0 is the magnitude stage, 1..DIV_STAGES are divider stages
   logic [MAG_W-1:0]  rem_ff [DIV_STAGES+1];
   logic [MAG_W-1:0]  rem_in [DIV_STAGES+1];
   logic [QUO_W-1:0]  quo_ff [DIV_STAGES+1];
   logic [QUO_W-1:0]  quo_in [DIV_STAGES+1];
   logic [CAL_W-1:0]  den_ff [DIV_STAGES+1];
   logic              neg_ff [DIV_STAGES+1];
   logic              ovf_ff [DIV_STAGES+1];

   logic [CAL_W-1:0]   den_in;
   logic               neg_in;
   logic               ovf_in;
   logic [COORD_W-1:0] result_ff, result_in;

   // Raw difference and calibration span
   always_comb begin
      diff_in = $signed({1'b0, raw}) - $signed({1'b0, from});
      span_in = $signed({1'b0, to}) - $signed({1'b0, from});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff <= diff_in;
         span_ff <= span_in;
      end
   end

   // Scale by the screen size
   assign prod_in = PROD_W'(diff_ff) * PROD_W'(SIZE_S);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         prod_ff  <= prod_in;
         span1_ff <= span_ff;
      end
   end

   // Take magnitudes, sign of the quotient and the quotient overflow check
   always_comb begin
      logic [DIFF_W-1:0] span_abs;
      span_abs   = span1_ff[DIFF_W-1] ? DIFF_W'(-span1_ff) : DIFF_W'(span1_ff);
      rem_in[0]  = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
      quo_in[0]  = '0;
      den_in     = span_abs[CAL_W-1:0];
      neg_in     = prod_ff[PROD_W-1] ^ span1_ff[DIFF_W-1];
      ovf_in     = CMP_W'(rem_in[0]) >= {den_in, {QUO_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= den_in;
         neg_ff[0] <= neg_in;
         ovf_ff[0] <= ovf_in;
      end
   end

   // Restoring divider, DIV_STEP quotient bits per stage
   for (genvar d = 1; d <= DIV_STAGES; d++) begin : g_div
      always_comb begin
         logic [MAG_W-1:0] r;
         logic [QUO_W-1:0] q;
         logic [CMP_W-1:0] cmp;
         int               b;
         r = rem_ff[d-1];
         q = quo_ff[d-1];
         for (int s = 0; s < DIV_STEP; s++) begin
            b   = QUO_W - 1 - (d - 1) * DIV_STEP - s;
            cmp = CMP_W'(den_ff[d-1]) << b;
            if (CMP_W'(r) >= cmp) begin
               r    = r - cmp[MAG_W-1:0];
               q[b] = 1'b1;
            end
         end
         rem_in[d] = r;
         quo_in[d] = q;
      end

      always_ff @(posedge clock) begin
         if (stage_en[2+d]) begin
            rem_ff[d] <= rem_in[d];
            quo_ff[d] <= quo_in[d];
            den_ff[d] <= den_ff[d-1];
            neg_ff[d] <= neg_ff[d-1];
            ovf_ff[d] <= ovf_ff[d-1];
         end
      end
   end

   // Apply sign and saturate to 16-bit signed
   always_comb begin
      logic [QUO_W-1:0] q;
      q = quo_ff[DIV_STAGES];
      if (neg_ff[DIV_STAGES]) begin
         if (ovf_ff[DIV_STAGES] || q > 16'h8000) begin
            result_in = 16'h8000;
         end else begin
            result_in = 16'h0000 - q;
         end
      end else begin
         if (ovf_ff[DIV_STAGES] || q[QUO_W-1]) begin
            result_in = 16'h7FFF;
         end else begin
            result_in = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[SAT_STAGE]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
